FILE: rtl/tpr_pkg.sv
// Package for the Thumb peephole rewriter: payload types, rule table and codes.
package tpr_pkg;

   localparam int CodeDepth = 4096;
   localparam int AddrWidth = $clog2(CodeDepth);
   localparam int LenWidth = AddrWidth + 1;
   localparam int NumRules = 13;
   localparam int MaxPat = 5;
   localparam int RuleWidth = $clog2(NumRules + 1);
   localparam int PosWidth = $clog2(MaxPat + 1);

   localparam logic [1:0] ModeAppend = 2'd0;
   localparam logic [1:0] ModeRead = 2'd1;
   localparam logic [1:0] ModeClear = 2'd2;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusFull = 2'd1;
   localparam logic [1:0] StatusRange = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [15:0] code_word;
      logic [11:0] read_index;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic [12:0] code_length;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic [2:0] npat;
      logic [2:0] nrep;
      logic [4:0][15:0] pat;
      logic [4:0][15:0] msk;
      logic [4:0][15:0] rep;
      logic [1:0] src_use;
      logic [1:0][2:0] src;
      logic [1:0][2:0] dst;
      logic [1:0][3:0] shl;
   } rule_type;

   // Word index 0 of each array is the oldest word of the pattern.
   function automatic rule_type rule_get(input logic [RuleWidth-1:0] idx);
      rule_type r;
      r = '0;
      unique case (idx)
         4'd0: begin
            r.npat = 3'd4; r.nrep = 3'd2;
            r.pat = {16'h0, 16'hbc08, 16'h2000, 16'hb401, 16'h4638};
            r.msk = {16'h0, 16'hffff, 16'hff00, 16'hffff, 16'hffff};
            r.rep = {48'h0, 16'h2000, 16'h463b};
            r.src_use = 2'b01; r.src[0] = 3'd2; r.dst[0] = 3'd1;
         end
         4'd1: begin
            r.npat = 3'd4; r.nrep = 3'd2;
            r.pat = {16'h0, 16'hbc08, 16'h2000, 16'hb401, 16'h6800};
            r.msk = {16'h0, 16'hffff, 16'hff00, 16'hffff, 16'hff00};
            r.rep = {48'h0, 16'h2000, 16'h6803};
            r.src_use = 2'b11; r.src[0] = 3'd0; r.dst[0] = 3'd0;
            r.src[1] = 3'd2; r.dst[1] = 3'd1;
         end
         4'd2: begin
            r.npat = 3'd3; r.nrep = 3'd2;
            r.pat = {32'h0, 16'h4438, 16'h4240, 16'h2000};
            r.msk = {32'h0, 16'hffff, 16'hffff, 16'hff00};
            r.rep = {48'h0, 16'h3800, 16'h4638};
            r.src_use = 2'b01; r.src[0] = 3'd0; r.dst[0] = 3'd1;
         end
         4'd3: begin
            r.npat = 3'd2; r.nrep = 3'd0;
            r.pat = {48'h0, 16'hbc01, 16'hb401};
            r.msk = {48'h0, 16'hffff, 16'hffff};
         end
         4'd4: begin
            r.npat = 3'd3; r.nrep = 3'd1;
            r.pat = {32'h0, 16'hbc02, 16'hb401, 16'h2000};
            r.msk = {32'h0, 16'hffff, 16'hffff, 16'hff00};
            r.rep = {64'h0, 16'h2100};
            r.src_use = 2'b01; r.src[0] = 3'd0; r.dst[0] = 3'd0;
         end
         4'd5: begin
            r.npat = 3'd5; r.nrep = 3'd2;
            r.pat = {16'hbc08, 16'h2000, 16'hb401, 16'h3804, 16'h4638};
            r.msk = {16'hffff, 16'hff00, 16'hffff, 16'hffff, 16'hffff};
            r.rep = {48'h0, 16'h2000, 16'h1f3b};
            r.src_use = 2'b01; r.src[0] = 3'd3; r.dst[0] = 3'd1;
         end
         4'd6: begin
            r.npat = 3'd5; r.nrep = 3'd3;
            r.pat = {16'hbc08, 16'h2000, 16'hb401, 16'h3800, 16'h4638};
            r.msk = {16'hffff, 16'hff00, 16'hffff, 16'hff00, 16'hffff};
            r.rep = {32'h0, 16'h2000, 16'h3b00, 16'h463b};
            r.src_use = 2'b11; r.src[0] = 3'd1; r.dst[0] = 3'd1;
            r.src[1] = 3'd3; r.dst[1] = 3'd2;
         end
         4'd7: begin
            r.npat = 3'd2; r.nrep = 3'd1;
            r.pat = {48'h0, 16'h6800, 16'h4638};
            r.msk = {48'h0, 16'hffff, 16'hffff};
            r.rep = {64'h0, 16'h6838};
         end
         4'd8: begin
            r.npat = 3'd2; r.nrep = 3'd1;
            r.pat = {48'h0, 16'h4358, 16'h2004};
            r.msk = {48'h0, 16'hffff, 16'hffff};
            r.rep = {64'h0, 16'h0098};
         end
         4'd9: begin
            r.npat = 3'd2; r.nrep = 3'd1;
            r.pat = {48'h0, 16'h3804, 16'h4638};
            r.msk = {48'h0, 16'hffff, 16'hffff};
            r.rep = {64'h0, 16'h1f38};
         end
         4'd10: begin
            r.npat = 3'd3; r.nrep = 3'd2;
            r.pat = {32'h0, 16'hbc02, 16'h2000, 16'hb401};
            r.msk = {32'h0, 16'hffff, 16'hff00, 16'hffff};
            r.rep = {48'h0, 16'h2000, 16'h4601};
            r.src_use = 2'b01; r.src[0] = 3'd1; r.dst[0] = 3'd1;
         end
         4'd11: begin
            r.npat = 3'd2; r.nrep = 3'd1;
            r.pat = {48'h0, 16'hbc02, 16'hb401};
            r.msk = {48'h0, 16'hffff, 16'hffff};
            r.rep = {64'h0, 16'h4601};
         end
         4'd12: begin
            r.npat = 3'd3; r.nrep = 3'd1;
            r.pat = {32'h0, 16'h6800, 16'h4438, 16'h2000};
            r.msk = {32'h0, 16'hffff, 16'hffff, 16'hff83};
            r.rep = {64'h0, 16'h6838};
            r.src_use = 2'b01; r.src[0] = 3'd0; r.dst[0] = 3'd0;
            r.shl[0] = 4'd4;
         end
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/tpr_window.sv
// Tail window: the last few stored words, kept in flip-flops beside the store.
module tpr_window (
   input logic clock,
   input logic load,
   input logic [tpr_pkg::MaxPat-1:0][15:0] load_words,
   output logic [tpr_pkg::MaxPat-1:0][15:0] words
);
   import tpr_pkg::*;

   logic [MaxPat-1:0][15:0] words_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         words_ff <= load_words;
      end
   end

   assign words = words_ff;
endmodule

FILE: rtl/thumb_peephole_rewriter_core.sv
// Top level of the Thumb peephole rewriter: store, rule sequencer and handshakes.
//
// Requests arrive on req_ (valid/ready) as one req_type struct; each gives one
// response on rsp_ as a rsp_type struct. Mode append writes a halfword and then
// walks the 13 rewrite rules in table order, one rule per cycle through a
// shared masked compare unit; after a match the rewritten words are written
// back one per cycle and the walk restarts at the first rule. The window of
// the last five words is refilled from the store after each rewrite, each
// word read in StFill and loaded in StFillW. An append without a match steps
// through StCheck once per rule and then StResp; a read goes through StRead
// and StRData (store read port is registered) and then StResp; a clear, a
// dropped append or a read out of range goes straight to StResp, which sets
// the response and its valid. Each rewrite adds StWrite and the window refill.
// One request is handled at a time: req_ready is low while a request is in
// progress or its response has not been taken. A stalled receiver simply
// holds the response register and its valid.
// After a synchronous reset the store is empty (length zero); the store's
// contents are never cleared, since words beyond the length are unreadable.
module thumb_peephole_rewriter_core (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input tpr_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output tpr_pkg::rsp_type rsp_data
);
   import tpr_pkg::*;

   typedef enum logic [7:0] {
      StIdle  = 8'b0000_0001,
      StRead  = 8'b0000_0010,
      StRData = 8'b0000_0100,
      StFill  = 8'b0000_1000,
      StCheck = 8'b0001_0000,
      StWrite = 8'b0010_0000,
      StResp  = 8'b0100_0000,
      StFillW = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [LenWidth-1:0] len_ff, len_in;
   logic [RuleWidth-1:0] rule_ff, rule_in;
   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [MaxPat-1:0][15:0] rep_ff, rep_in;
   logic [2:0] nrep_ff, nrep_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [15:0] mem [CodeDepth];
   logic [15:0] rd_data_ff;
   logic mem_we;
   logic [AddrWidth-1:0] mem_waddr, mem_raddr;
   logic [15:0] mem_wdata;

   logic win_load;
   logic [MaxPat-1:0][15:0] win_words, win_next;

   rule_type rule;
   logic match;
   logic [MaxPat-1:0][15:0] cap;
   logic [MaxPat-1:0][15:0] rep_built;
   logic [LenWidth-1:0] base;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   tpr_window u_window (
      .clock(clock),
      .load(win_load),
      .load_words(win_next),
      .words(win_words)
   );

   // Window word k holds store entry len-1-k; pattern word i sits at len-npat+i.
   always_comb begin
      logic [15:0] w;
      logic [PosWidth-1:0] k;
      rule = rule_get(rule_ff);
      match = (len_ff >= LenWidth'(rule.npat));
      cap = '0;
      for (int i = 0; i < MaxPat; i++) begin
         k = PosWidth'(rule.npat) - PosWidth'(i) - PosWidth'(1);
         w = win_words[k[2:0]];
         if (3'(i) < rule.npat) begin
            if ((w & rule.msk[i]) != rule.pat[i]) begin
               match = 1'b0;
            end
            cap[i] = w & ~rule.msk[i];
         end
      end
      rep_built = rule.rep;
      for (int j = 0; j < 2; j++) begin
         if (rule.src_use[j]) begin
            rep_built[rule.dst[j]] = rep_built[rule.dst[j]] |
               16'(cap[rule.src[j]] << rule.shl[j]);
         end
      end
      base = len_ff - LenWidth'(rule.npat);
   end

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      rule_in = rule_ff;
      pos_in = pos_ff;
      rep_in = rep_ff;
      nrep_in = nrep_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we = 1'b0;
      mem_waddr = len_ff[AddrWidth-1:0];
      mem_wdata = req_ff.code_word;
      mem_raddr = req_ff.read_index;
      win_load = 1'b0;
      win_next = win_words;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         StIdle: begin
            if (req_valid && !rsp_valid_ff) begin
               req_in = req_data;
               rsp_in = '0;
               unique case (req_data.mode)
                  ModeAppend: begin
                     if (len_ff >= LenWidth'(CodeDepth)) begin
                        rsp_in.status = StatusFull;
                        state_in = StResp;
                     end else begin
                        mem_we = 1'b1;
                        mem_wdata = req_data.code_word;
                        len_in = len_ff + 1'b1;
                        win_load = 1'b1;
                        win_next = {win_words[MaxPat-2:0], req_data.code_word};
                        rule_in = '0;
                        state_in = StCheck;
                     end
                  end
                  ModeRead: begin
                     if (LenWidth'(req_data.read_index) < len_ff) begin
                        state_in = StRead;
                     end else begin
                        rsp_in.status = StatusRange;
                        state_in = StResp;
                     end
                  end
                  ModeClear: begin
                     len_in = '0;
                     state_in = StResp;
                  end
                  default: state_in = StResp;
               endcase
            end
         end
         StRead: state_in = StRData;
         StRData: begin
            rsp_in.read_data = rd_data_ff;
            state_in = StResp;
         end
         StCheck: begin
            if (match) begin
               rep_in = rep_built;
               nrep_in = rule.nrep;
               len_in = base;
               pos_in = '0;
               state_in = StWrite;
            end else if (rule_ff == RuleWidth'(NumRules - 1)) begin
               state_in = StResp;
            end else begin
               rule_in = rule_ff + 1'b1;
            end
         end
         StWrite: begin
            // Append replacement words one per cycle, then refill the window.
            if (3'(pos_ff) < nrep_ff) begin
               mem_we = 1'b1;
               mem_waddr = len_ff[AddrWidth-1:0];
               mem_wdata = rep_ff[pos_ff[2:0]];
               len_in = len_ff + 1'b1;
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = '0;
               win_load = 1'b1;
               win_next = '0;
               state_in = StFill;
            end
         end
         StFill: begin
            // Read entry len-1-pos; the registered read data is taken up in StFillW.
            mem_raddr = AddrWidth'(len_ff - LenWidth'(pos_ff) - 1'b1);
            state_in = StFillW;
         end
         StFillW: begin
            win_load = 1'b1;
            if (LenWidth'(pos_ff) < len_ff) begin
               win_next[pos_ff[2:0]] = rd_data_ff;
            end
            if (pos_ff == PosWidth'(MaxPat - 1)) begin
               rule_in = '0;
               state_in = StCheck;
            end else begin
               pos_in = pos_ff + 1'b1;
               state_in = StFill;
            end
         end
         StResp: begin
            rsp_in.code_length = 13'(len_ff);
            rsp_valid_in = 1'b1;
            state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         len_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rule_ff <= rule_in;
      pos_ff <= pos_in;
      rep_ff <= rep_in;
      nrep_ff <= nrep_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == StIdle) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
